// File: design/scmr_pkg.sv
`default_nettype none

package scmr_pkg;

   localparam int COEF_W      = 64;
   localparam int MOD_W       = 32;
   localparam int DIV_STAGES  = COEF_W;
   localparam int BACK_STAGES = 3;
   localparam int PIPE_DEPTH  = 1 + DIV_STAGES + BACK_STAGES;
   localparam int COUNT_W     = $clog2(PIPE_DEPTH + 1);

   localparam logic [MOD_W-1:0] MOD_RESET = 32'd1073479681;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_ADD = 1'b1;

   typedef struct packed {
      logic              op;
      logic              neg;
      logic [MOD_W-1:0]  acc;
      logic [MOD_W-1:0]  rem;
      logic [COEF_W-1:0] mag;
   } scmr_item_type;

endpackage

`default_nettype wire

// File: design/scmr_front.sv
`default_nettype none

module scmr_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               enable,
   input  wire                               in_valid,
   input  wire                               operation,
   input  wire signed [scmr_pkg::COEF_W-1:0] coefficient,
   input  wire        [scmr_pkg::MOD_W-1:0]  accumulator,
   output logic                              out_valid,
   output scmr_pkg::scmr_item_type           out_item
);
   import scmr_pkg::*;

   scmr_item_type item_in;
   scmr_item_type item_ff;
   logic          valid_ff;

   always_comb begin
      item_in.op  = operation;
      item_in.neg = coefficient[COEF_W-1];
      item_in.acc = accumulator;
      item_in.rem = '0;
      // magnitude; the most negative value maps to 2^63 as unsigned
      item_in.mag = coefficient[COEF_W-1] ? (~coefficient + COEF_W'(1)) : coefficient;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: design/scmr_div_step.sv
`default_nettype none

module scmr_div_step (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              enable,
   input  wire                              in_valid,
   input  scmr_pkg::scmr_item_type          in_item,
   input  wire       [scmr_pkg::MOD_W-1:0]  modulus,
   output logic                             out_valid,
   output scmr_pkg::scmr_item_type          out_item
);
   import scmr_pkg::*;

   logic [MOD_W:0]   cand;
   logic [MOD_W+1:0] diff;
   scmr_item_type    item_in;
   scmr_item_type    item_ff;
   logic             valid_ff;

   // one restoring remainder step: shift in the next magnitude bit
   always_comb begin
      cand        = {in_item.rem, in_item.mag[COEF_W-1]};
      diff        = {1'b0, cand} - {2'b00, modulus};
      item_in     = in_item;
      item_in.rem = diff[MOD_W+1] ? cand[MOD_W-1:0] : diff[MOD_W-1:0];
      item_in.mag = {in_item.mag[COEF_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: design/scmr_back.sv
`default_nettype none

module scmr_back (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire [scmr_pkg::BACK_STAGES-1:0]         enable,
   input  wire                                     in_valid,
   input  scmr_pkg::scmr_item_type                 in_item,
   input  wire [scmr_pkg::MOD_W-1:0]               modulus,
   output logic [scmr_pkg::BACK_STAGES-1:0]        out_valid,
   output logic [scmr_pkg::MOD_W-1:0]              residue
);
   import scmr_pkg::*;

   logic [BACK_STAGES-1:0] valid_in;
   logic [BACK_STAGES-1:0] valid_ff;

   logic [MOD_W-1:0]   rem_in;
   logic [MOD_W-1:0]   rem_ff;
   logic               op_ff;
   logic [MOD_W-1:0]   acc_ff;
   logic [MOD_W:0]     sum_in;
   logic [MOD_W:0]     sum_ff;
   logic [MOD_W+1:0]   diff;
   logic [MOD_W-1:0]   residue_in;
   logic [MOD_W-1:0]   residue_ff;

   assign valid_in = {valid_ff[BACK_STAGES-2:0], in_valid};

   // sign fix: negative input maps to modulus minus remainder, zero stays zero, and a zero modulus gives zero
   always_comb begin
      if (modulus == '0) begin
         rem_in = '0;
      end else if (in_item.neg && (in_item.rem != '0)) begin
         rem_in = modulus - in_item.rem;
      end else begin
         rem_in = in_item.rem;
      end
   end

   assign sum_in = (op_ff == OP_ADD) ? ({1'b0, acc_ff} + {1'b0, rem_ff}) : {1'b0, rem_ff};

   always_comb begin
      diff       = {1'b0, sum_ff} - {2'b00, modulus};
      residue_in = diff[MOD_W+1] ? sum_ff[MOD_W-1:0] : diff[MOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < BACK_STAGES; i++) begin
            if (enable[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable[0]) begin
         rem_ff <= rem_in;
         op_ff  <= in_item.op;
         acc_ff <= in_item.acc;
      end
      if (enable[1]) begin
         sum_ff <= sum_in;
      end
      if (enable[2]) begin
         residue_ff <= residue_in;
      end
   end

   assign out_valid = valid_ff;
   assign residue   = residue_ff;

endmodule

`default_nettype wire

// File: design/signed_coefficient_mod_reduce.sv
// Signed coefficient reduction: maps a signed 64-bit coefficient to its
// residue in 0 .. modulus-1, or adds that residue to an accumulator mod modulus.
// Request channel (req_*): operation, coefficient, accumulator, valid/ready.
// Response channel (rsp_*): residue, valid/ready; one response per request, in order.
// Register port (csr_*): writes the modulus, always ready; write only while idle.
// Pipeline: request accept to rsp_valid runs through 1 magnitude stage,
// 64 one-bit remainder stages, 3 stages for sign fix, add and final subtract.
// Throughput: one request per cycle while req_ready is high, set by the one-bit-per-stage remainder chain.
// Reset: synchronous; empties the pipeline and sets the modulus to 1073479681.
// Stall: the last stage holds the response; earlier stages keep moving into
// empty slots, and req_ready drops only once all 68 stages hold a request.
`default_nettype none

module signed_coefficient_mod_reduce (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_operation,
   input  wire signed [scmr_pkg::COEF_W-1:0]  req_coefficient,
   input  wire        [scmr_pkg::MOD_W-1:0]   req_accumulator,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic       [scmr_pkg::MOD_W-1:0]   rsp_residue,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire        [scmr_pkg::MOD_W-1:0]   csr_modulus
);
   import scmr_pkg::*;

   logic [MOD_W-1:0]      modulus_ff;
   logic [PIPE_DEPTH-1:0] stage_valid;
   logic [PIPE_DEPTH-1:0] stage_en;
   scmr_item_type         chain [DIV_STAGES+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_RESET;
      end else if (csr_valid) begin
         modulus_ff <= csr_modulus;
      end
   end

   // a stage loads when it or any later stage is empty, or the output drains
   for (genvar i = 0; i < PIPE_DEPTH; i++) begin : g_en
      assign stage_en[i] = rsp_ready | ~(&stage_valid[PIPE_DEPTH-1:i]);
   end

   assign req_ready = stage_en[0];

   scmr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (stage_en[0]),
      .in_valid    (req_valid),
      .operation   (req_operation),
      .coefficient (req_coefficient),
      .accumulator (req_accumulator),
      .out_valid   (stage_valid[0]),
      .out_item    (chain[0])
   );

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      scmr_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (stage_en[k+1]),
         .in_valid  (stage_valid[k]),
         .in_item   (chain[k]),
         .modulus   (modulus_ff),
         .out_valid (stage_valid[k+1]),
         .out_item  (chain[k+1])
      );
   end

   scmr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (stage_en[PIPE_DEPTH-1:DIV_STAGES+1]),
      .in_valid  (stage_valid[DIV_STAGES]),
      .in_item   (chain[DIV_STAGES]),
      .modulus   (modulus_ff),
      .out_valid (stage_valid[PIPE_DEPTH-1:DIV_STAGES+1]),
      .residue   (rsp_residue)
   );

   assign rsp_valid = stage_valid[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// File: design/scmr_checker.sv
`default_nettype none

module scmr_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire        [scmr_pkg::MOD_W-1:0]  rsp_residue
);
   import scmr_pkg::*;

   logic [COUNT_W-1:0] pending_ff;
   logic [COUNT_W-1:0] pending_in;
   logic               req_fire;
   logic               rsp_fire;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + COUNT_W'(1);
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residue))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without an outstanding request");

   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && pending_ff == COUNT_W'(PIPE_DEPTH))
      else $error("request refused while pipeline has room");

endmodule

bind signed_coefficient_mod_reduce scmr_checker u_checker (.*);

`default_nettype wire
